>>> sv/rlv_pkg.sv
`timescale 1ns / 1ps
package rlv_pkg;

	localparam int IN_W      = 16;
	localparam int OUT_W     = 32;
	localparam int CW        = 2 * IN_W + 1;
	localparam int MW        = 2 * IN_W;
	localparam int VW        = CW + IN_W + 2;
	localparam int AVW       = VW - 1;
	localparam int KW        = 32;
	localparam int PW        = MW + KW;
	localparam int DIV_BITS  = OUT_W + 1;
	localparam int NW        = PW + 2 + DIV_BITS + 1;
	localparam int LANES     = 9;
	localparam int FRONT_LAT = 3;
	localparam int LANE_LAT  = DIV_BITS + 1;
	localparam int PIPE      = FRONT_LAT + LANE_LAT;

	// 2*pi in unsigned Q3.29
	localparam logic [KW-1:0] TWO_PI_Q29 = 32'd3373259426;

	typedef logic signed [IN_W-1:0]  in_t;
	typedef logic signed [OUT_W-1:0] out_t;

	typedef struct packed {
		in_t a1_x, a1_y, a1_z;
		in_t a2_x, a2_y, a2_z;
		in_t a3_x, a3_y, a3_z;
	} lattice_t;

	typedef struct packed {
		out_t r1_x, r1_y, r1_z;
		out_t r2_x, r2_y, r2_z;
		out_t r3_x, r3_y, r3_z;
		logic singular;
		logic saturated;
	} recip_t;

	typedef struct packed {
		logic [PW-1:0]        p;
		logic                 c_neg;
		logic signed [VW-1:0] vol;
	} lane_in_t;

	typedef struct packed {
		logic [DIV_BITS-1:0] q;
		logic                ov;
		logic                neg;
	} lane_out_t;

	typedef struct packed {
		lane_in_t [LANES-1:0] lane;
		logic                 vol_zero;
	} front_t;

	function automatic logic signed [CW-1:0] cross_c(in_t p, in_t q, in_t r, in_t s);
		return CW'(p * q) - CW'(r * s);
	endfunction

endpackage

>>> sv/rlv_front.sv
`timescale 1ns / 1ps
module rlv_front import rlv_pkg::*; (
	input  logic     clk,
	input  lattice_t lattice,
	output front_t   front
);

	in_t a [3][3];
	logic signed [CW-1:0]   c_s1 [LANES];
	in_t                    a1_s1 [3];
	logic signed [VW-1:0]   vp_s2 [3];
	logic [PW-1:0]          p_s2 [LANES];
	logic [LANES-1:0]       cneg_s2;
	logic signed [VW-1:0]   vol_s3;
	logic [PW-1:0]          p_s3 [LANES];
	logic [LANES-1:0]       cneg_s3;

	assign a[0][0] = lattice.a1_x;
	assign a[0][1] = lattice.a1_y;
	assign a[0][2] = lattice.a1_z;
	assign a[1][0] = lattice.a2_x;
	assign a[1][1] = lattice.a2_y;
	assign a[1][2] = lattice.a2_z;
	assign a[2][0] = lattice.a3_x;
	assign a[2][1] = lattice.a3_y;
	assign a[2][2] = lattice.a3_z;

	for (genvar i = 0; i < 3; i++) begin : g_vec
		for (genvar j = 0; j < 3; j++) begin : g_cmp
			localparam int U  = (i + 1) % 3;
			localparam int V  = (i + 2) % 3;
			localparam int J1 = (j + 1) % 3;
			localparam int J2 = (j + 2) % 3;
			logic [MW-1:0] mag;

			always_ff @(posedge clk) begin
				c_s1[i*3+j] <= cross_c(a[U][J1], a[V][J2], a[U][J2], a[V][J1]);
			end

			assign mag = c_s1[i*3+j][CW-1] ? MW'(-c_s1[i*3+j]) : MW'(c_s1[i*3+j]);

			always_ff @(posedge clk) begin
				p_s2[i*3+j]    <= PW'(mag) * PW'(TWO_PI_Q29);
				cneg_s2[i*3+j] <= c_s1[i*3+j][CW-1];
				p_s3[i*3+j]    <= p_s2[i*3+j];
				cneg_s3[i*3+j] <= cneg_s2[i*3+j];
			end

			assign front.lane[i*3+j].p     = p_s3[i*3+j];
			assign front.lane[i*3+j].c_neg = cneg_s3[i*3+j];
			assign front.lane[i*3+j].vol   = vol_s3;
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_vol
		always_ff @(posedge clk) begin
			a1_s1[j] <= a[0][j];
			vp_s2[j] <= VW'(c_s1[j] * a1_s1[j]);
		end
	end

	always_ff @(posedge clk) begin
		vol_s3 <= vp_s2[0] + vp_s2[1] + vp_s2[2];
	end

	assign front.vol_zero = (vol_s3 == '0);

endmodule

>>> sv/rlv_lane.sv
`timescale 1ns / 1ps
module rlv_lane import rlv_pkg::*; (
	input  logic      clk,
	input  lane_in_t  din,
	output lane_out_t dout
);

	logic [AVW-1:0]      absv;
	logic [NW-1:0]       num;
	logic [NW-1:0]       den;
	logic [NW-1:0]       rem_s [0:DIV_BITS];
	logic [NW-1:0]       den_s [0:DIV_BITS];
	logic [DIV_BITS-1:0] q_s   [0:DIV_BITS];
	logic                neg_s [0:DIV_BITS];
	logic                ov_s  [0:DIV_BITS];

	assign absv = din.vol[VW-1] ? AVW'(-din.vol) : AVW'(din.vol);
	assign den  = NW'(absv) << 6;
	assign num  = (NW'(din.p) << 1) + (NW'(absv) << 5);

	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den;
		q_s[0]   <= '0;
		neg_s[0] <= din.c_neg ^ din.vol[VW-1];
		ov_s[0]  <= num >= (den << DIV_BITS);
	end

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
		localparam int B = DIV_BITS - 1 - k;
		logic [NW-1:0] sub;
		logic          ge;

		assign sub = den_s[k] << B;
		assign ge  = rem_s[k] >= sub;

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? rem_s[k] - sub : rem_s[k];
			den_s[k+1] <= den_s[k];
			q_s[k+1]   <= {q_s[k][DIV_BITS-2:0], ge};
			neg_s[k+1] <= neg_s[k];
			ov_s[k+1]  <= ov_s[k];
		end
	end

	assign dout.q   = q_s[DIV_BITS];
	assign dout.ov  = ov_s[DIV_BITS];
	assign dout.neg = neg_s[DIV_BITS];

endmodule

>>> sv/reciprocal_lattice_vectors.sv
`timescale 1ns / 1ps
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------
// input    | start, busy        | lattice (a1..a3, signed Q8.8)
// result   | done (one cycle)   | recip (r1..r3 Q16.16, singular, saturated)
//
// One lattice per cycle; busy is never raised.
// Pipeline: cross-product and volume registers, a divider setup register,
// 33 restoring-divide stages (one quotient bit each, nine lanes), a merge register.
// arst_n clears the valid pipeline; data in flight is dropped.
// Results cannot be held off: done lasts one cycle per transfer.
module reciprocal_lattice_vectors import rlv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  lattice_t lattice,
	output logic     done,
	output recip_t   recip
);

	front_t           front;
	lane_out_t        lo [LANES];
	logic [PIPE-1:0]  vld_q;
	logic [LANE_LAT-1:0] sing_q;
	out_t             val [LANES];
	logic [LANES-1:0] sat;
	recip_t           recip_q;
	logic             done_q;

	assign busy = 1'b0;

	rlv_front u_front (
		.clk     (clk),
		.lattice (lattice),
		.front   (front)
	);

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [DIV_BITS-1:0] lim;
		logic [DIV_BITS-1:0] mag;

		rlv_lane u_lane (
			.clk  (clk),
			.din  (front.lane[l]),
			.dout (lo[l])
		);

		assign lim    = lo[l].neg ? DIV_BITS'(1) << (OUT_W - 1)
		                          : (DIV_BITS'(1) << (OUT_W - 1)) - DIV_BITS'(1);
		assign sat[l] = lo[l].ov || (lo[l].q > lim);
		assign mag    = sat[l] ? lim : lo[l].q;
		assign val[l] = lo[l].neg ? -OUT_W'(mag) : OUT_W'(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q  <= {vld_q[PIPE-2:0], start};
			done_q <= vld_q[PIPE-1];
		end
	end

	always_ff @(posedge clk) begin
		sing_q <= {sing_q[LANE_LAT-2:0], front.vol_zero};
		if (sing_q[LANE_LAT-1]) begin
			recip_q           <= '{singular: 1'b1, default: '0};
		end else begin
			recip_q.r1_x      <= val[0];
			recip_q.r1_y      <= val[1];
			recip_q.r1_z      <= val[2];
			recip_q.r2_x      <= val[3];
			recip_q.r2_y      <= val[4];
			recip_q.r2_z      <= val[5];
			recip_q.r3_x      <= val[6];
			recip_q.r3_y      <= val[7];
			recip_q.r3_z      <= val[8];
			recip_q.singular  <= 1'b0;
			recip_q.saturated <= |sat;
		end
	end

	assign done  = done_q;
	assign recip = recip_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(PIPE + 1) done)
		else $error("result missing after fixed latency");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && recip.singular) |-> (!recip.saturated && recip.r1_x == '0
			&& recip.r2_y == '0 && recip.r3_z == '0))
		else $error("singular result not cleared");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !busy)
		else $error("busy raised");

endmodule

>>> tb/reciprocal_lattice_vectors_tb.sv
`timescale 1ns / 1ps
module reciprocal_lattice_vectors_tb;
	import rlv_pkg::*;

	localparam int LAT      = 38;
	localparam int WD_LIMIT = 2000;
	localparam int N_RAND   = 400;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	lattice_t lattice;
	logic     done;
	recip_t   recip;

	reciprocal_lattice_vectors u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.lattice(lattice), .done(done), .recip(recip)
	);

	lattice_t pending_lattices[$];
	recip_t   expected_recips[$];
	int       errors = 0;
	int       idle_pct;
	bit       hold_off;
	int       quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// c*K/(V*32), rounded half away from zero, clamped to OUT_W
	function automatic out_t recip_component(logic signed [CW-1:0] c,
			logic signed [VW-1:0] vol, ref logic sat);
		logic [255:0] num, den, q;
		logic         neg;
		logic [255:0] lim;
		neg = c[CW-1] ^ vol[VW-1];
		den = 256'(vol[VW-1] ? -vol : vol) << 5;
		num = (256'(c[CW-1] ? -c : c) * 256'(TWO_PI_Q29)) * 2 + den;
		q   = num / (den * 2);
		lim = (256'(1) << (OUT_W - 1)) - 1 + neg;
		if (q > lim) begin
			sat = 1'b1;
			q = lim;
		end
		return neg ? out_t'(-q) : out_t'(q);
	endfunction

	function automatic recip_t reciprocal_of(lattice_t l);
		logic signed [VW-1:0] b1x, b1y, b1z, b2x, b2y, b2z, b3x, b3y, b3z, vol;
		logic sat;
		recip_t r;
		b1x = VW'(l.a2_y) * l.a3_z - VW'(l.a2_z) * l.a3_y;
		b1y = VW'(l.a2_z) * l.a3_x - VW'(l.a2_x) * l.a3_z;
		b1z = VW'(l.a2_x) * l.a3_y - VW'(l.a2_y) * l.a3_x;
		b2x = VW'(l.a3_y) * l.a1_z - VW'(l.a3_z) * l.a1_y;
		b2y = VW'(l.a3_z) * l.a1_x - VW'(l.a3_x) * l.a1_z;
		b2z = VW'(l.a3_x) * l.a1_y - VW'(l.a3_y) * l.a1_x;
		b3x = VW'(l.a1_y) * l.a2_z - VW'(l.a1_z) * l.a2_y;
		b3y = VW'(l.a1_z) * l.a2_x - VW'(l.a1_x) * l.a2_z;
		b3z = VW'(l.a1_x) * l.a2_y - VW'(l.a1_y) * l.a2_x;
		vol = b1x * l.a1_x + b1y * l.a1_y + b1z * l.a1_z;
		r = '0;
		sat = 1'b0;
		if (vol == 0) begin
			r.singular = 1'b1;
			return r;
		end
		r.r1_x = recip_component(CW'(b1x), vol, sat);
		r.r1_y = recip_component(CW'(b1y), vol, sat);
		r.r1_z = recip_component(CW'(b1z), vol, sat);
		r.r2_x = recip_component(CW'(b2x), vol, sat);
		r.r2_y = recip_component(CW'(b2y), vol, sat);
		r.r2_z = recip_component(CW'(b2z), vol, sat);
		r.r3_x = recip_component(CW'(b3x), vol, sat);
		r.r3_y = recip_component(CW'(b3y), vol, sat);
		r.r3_z = recip_component(CW'(b3z), vol, sat);
		r.saturated = sat;
		return r;
	endfunction

	function automatic in_t rand_comp(int mode);
		case (mode)
			0: return in_t'($urandom);
			1: return in_t'($urandom_range(0, 1023)) - in_t'(512);
			2: return in_t'($urandom_range(0, 7)) - in_t'(3);
			default: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
		endcase
	endfunction

	function automatic lattice_t rand_lattice();
		lattice_t l;
		int m;
		m = $urandom_range(0, 9);
		m = (m < 4) ? 0 : (m < 7) ? 1 : (m < 9) ? 2 : 3;
		l.a1_x = rand_comp(m); l.a1_y = rand_comp(m); l.a1_z = rand_comp(m);
		l.a2_x = rand_comp(m); l.a2_y = rand_comp(m); l.a2_z = rand_comp(m);
		l.a3_x = rand_comp(m); l.a3_y = rand_comp(m); l.a3_z = rand_comp(m);
		// sometimes make the cell degenerate: a3 a multiple of a1
		if ($urandom_range(0, 15) == 0) begin
			l.a3_x = l.a1_x; l.a3_y = l.a1_y; l.a3_z = l.a1_z;
		end
		return l;
	endfunction

	function automatic lattice_t diag(in_t a, in_t b, in_t c);
		lattice_t l;
		l = '0;
		l.a1_x = a; l.a2_y = b; l.a3_z = c;
		return l;
	endfunction

	task automatic check_field(string name, out_t exp_v, out_t act_v);
		if (act_v !== exp_v) begin
			$error("%s exp %0d got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			lattice <= '0;
		end else begin
			if (start && !busy)
				void'(pending_lattices.pop_front());
			if (pending_lattices.size() > 0 && !hold_off
					&& $urandom_range(0, 99) >= idle_pct) begin
				start <= 1'b1;
				lattice <= pending_lattices[0];
			end else if (!(start && busy)) begin
				start <= 1'b0;
				lattice <= lattice_t'(144'({$urandom, $urandom, $urandom, $urandom,
					$urandom}));
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (start && !busy)
				expected_recips.push_back(reciprocal_of(lattice));
			if (done) begin
				if (expected_recips.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					recip_t e;
					e = expected_recips.pop_front();
					check_field("r1_x", e.r1_x, recip.r1_x);
					check_field("r1_y", e.r1_y, recip.r1_y);
					check_field("r1_z", e.r1_z, recip.r1_z);
					check_field("r2_x", e.r2_x, recip.r2_x);
					check_field("r2_y", e.r2_y, recip.r2_y);
					check_field("r2_z", e.r2_z, recip.r2_z);
					check_field("r3_x", e.r3_x, recip.r3_x);
					check_field("r3_y", e.r3_y, recip.r3_y);
					check_field("r3_z", e.r3_z, recip.r3_z);
					if (recip.singular !== e.singular) begin
						$error("singular exp %0b got %0b", e.singular, recip.singular); errors++;
					end
					if (recip.saturated !== e.saturated) begin
						$error("saturated exp %0b got %0b", e.saturated, recip.saturated); errors++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n && quiet_cycles >= WD_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		lattice_t l;
		idle_pct = 36;
		hold_off = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		pending_lattices.push_back(diag(16'sh0100, 16'sh0100, 16'sh0100));
		pending_lattices.push_back(diag(16'sh7fff, 16'sh7fff, 16'sh7fff));
		pending_lattices.push_back(diag(16'sh8000, 16'sh8000, 16'sh8000));
		pending_lattices.push_back(diag(16'sh0001, 16'sh0001, 16'sh0001));
		pending_lattices.push_back(diag(16'shffff, 16'sh0001, 16'sh0001));
		pending_lattices.push_back(diag(16'sh8000, 16'sh7fff, 16'sh0001));
		pending_lattices.push_back(diag(16'sh0000, 16'sh0100, 16'sh0100));
		pending_lattices.push_back('0);
		l = diag(16'sh0100, 16'sh0100, 16'sh0100);
		l.a3_x = 16'sh0100; l.a3_z = 16'sh0000;
		pending_lattices.push_back(l);
		l = diag(16'sh0300, 16'sh0300, 16'sh0300);
		pending_lattices.push_back(l);
		l.a1_y = 16'sh7fff; l.a2_z = 16'sh8000; l.a3_x = 16'sh7fff;
		pending_lattices.push_back(l);
		l = diag(16'sh0001, 16'sh0002, 16'sh0003);
		pending_lattices.push_back(l);
		l = '1;
		pending_lattices.push_back(l);
		l = diag(16'sh5555, 16'shaaaa, 16'sh5555);
		l.a1_y = 16'shaaaa; l.a2_z = 16'sh5555; l.a3_x = 16'shaaaa;
		pending_lattices.push_back(l);
		wait (pending_lattices.size() == 0);

		// pause until everything in flight has drained
		hold_off = 1'b1;
		wait (expected_recips.size() == 0);
		@(negedge clk);
		hold_off = 1'b0;

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 36 : (ph == 1) ? 68 : 0;
			for (int i = 0; i < N_RAND / 3; i++)
				pending_lattices.push_back(rand_lattice());
			wait (pending_lattices.size() == 0);
		end

		@(negedge clk);
		wait (expected_recips.size() == 0);
		repeat (LAT + 5) @(posedge clk);
		if (errors == 0 && expected_recips.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
